[hdl/pair_sum_complement_finder_unit_defines.svh]
// Assertion macros for the top-level RTL file of the pair sum unit.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef PAIR_SUM_COMPLEMENT_FINDER_UNIT_DEFINES_SVH
`define PAIR_SUM_COMPLEMENT_FINDER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PSC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define PSC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSC_ASSERT_ALWAYS(lbl, expr, msg)
`define PSC_ASSERT_SAME(lbl, ante, cons, msg)
`define PSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/psc_pkg.sv]
package psc_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_POSITION_BITS = 16;
    localparam int VALUE_W           = 32;
    localparam int OUT_POS_W         = 16;
    localparam int STATUS_W          = 2;

    // Result codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_STORED  = 2'd0,
        ST_PAIR    = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FULL    = 2'd3
    } t_psc_status;

    // Search token that walks down the row of cells.
    typedef struct packed {
        logic valid;
        logic comp_hit;
        logic dup_hit;
    } t_psc_token;

    // Write strobes broadcast to every cell.
    typedef struct packed {
        logic value_we;
        logic pos_we;
    } t_psc_wr;

endpackage

[hdl/pair_sum_complement_finder_unit.sv]
// Streaming two-sum search. Each transaction offered on i_value with start high while busy
// is low is accepted, and exactly one result comes back on o_status, o_earlier_position and
// o_current_position, marked by o_result_valid for a single cycle. The receiver cannot stall
// the unit, so results must be captured in the cycle in which the strobe is high. An item
// that needs a table lookup walks a row of TABLE_ENTRIES cells, one cell per clock, so its
// result strobe is registered after the token has left the last cell, and busy stays high
// until the strobe cycle, in which a new transaction may be offered. An item that arrives
// after a pair has been found, or once the position counter has saturated, needs no lookup:
// its result strobe follows in the very next cycle and busy does not rise. The target sum is
// written through i_cfg_valid and o_cfg_ready while the unit is not busy.
`include "pair_sum_complement_finder_unit_defines.svh"

module pair_sum_complement_finder_unit #(
    parameter int TABLE_ENTRIES = psc_pkg::DEF_TABLE_ENTRIES,
    parameter int POSITION_BITS = psc_pkg::DEF_POSITION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Item transaction
    input  logic                          start,
    output logic                          busy,
    input  logic [psc_pkg::VALUE_W-1:0]   i_value,
    input  logic                          i_start_req,
    // Result transaction
    output logic                          o_result_valid,
    output logic [psc_pkg::STATUS_W-1:0]  o_status,
    output logic [psc_pkg::OUT_POS_W-1:0] o_earlier_position,
    output logic [psc_pkg::OUT_POS_W-1:0] o_current_position,
    // Configuration transaction
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [psc_pkg::VALUE_W-1:0]   i_target_sum
);
    import psc_pkg::*;

    localparam int FW = $clog2(TABLE_ENTRIES + 1);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = POSITION_BITS + 1;
    localparam logic [FW-1:0] FILL_MAX = FW'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [VALUE_W-1:0]       r_target;
    logic [FW-1:0]            r_fill, n_fill;
    logic [CW-1:0]            r_pos_cnt, n_pos_cnt;
    logic                     r_pair_done, n_pair_done;
    logic                     r_launch, n_launch;
    logic [VALUE_W:0]         r_comp, n_comp;
    logic [VALUE_W-1:0]       r_key_value, n_key_value;
    logic [POSITION_BITS-1:0] r_cur_pos, n_cur_pos;
    logic                     r_out_valid, n_out_valid;
    t_psc_status              r_status, n_status;
    logic [OUT_POS_W-1:0]     r_early, n_early;
    logic [OUT_POS_W-1:0]     r_cur_out, n_cur_out;

    logic                     accept;
    logic                     done;
    logic [CW-1:0]            pc_eff;
    logic                     pair_eff;
    logic [FW-1:0]            fill_eff;
    logic [VALUE_W:0]         comp;
    t_psc_wr                  wr;
    logic [IW-1:0]            wr_idx;

    // Links of the cell row; entry k feeds cell k, entry TABLE_ENTRIES is the row's end.
    t_psc_token               tok      [TABLE_ENTRIES+1];
    logic [POSITION_BITS-1:0] hit_pos  [TABLE_ENTRIES+1];
    logic [IW-1:0]            dup_idx  [TABLE_ENTRIES+1];

    assign busy        = (r_state == S_SEARCH);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;

    // A start mark clears the table, the position and the pair flag before the item is handled.
    assign pc_eff   = i_start_req ? '0   : r_pos_cnt;
    assign pair_eff = i_start_req ? 1'b0 : r_pair_done;
    assign fill_eff = i_start_req ? '0   : r_fill;

    // The difference is formed one bit wider than the operands, so it never wraps.
    assign comp = {r_target[VALUE_W-1], r_target} - {i_value[VALUE_W-1], i_value};

    assign done = (r_state == S_SEARCH) && tok[TABLE_ENTRIES].valid;

    assign tok[0]     = '{valid: r_launch, comp_hit: 1'b0, dup_hit: 1'b0};
    assign hit_pos[0] = '0;
    assign dup_idx[0] = '0;

    // Table update once the token has passed every cell. A complement hit wins; otherwise a
    // value already held only has its position refreshed, and a new value takes the next free
    // cell when there is one.
    always_comb begin
        wr     = '0;
        wr_idx = r_fill[IW-1:0];
        if (done && !tok[TABLE_ENTRIES].comp_hit) begin
            if (tok[TABLE_ENTRIES].dup_hit) begin
                wr.pos_we = 1'b1;
                wr_idx    = dup_idx[TABLE_ENTRIES];
            end else if (r_fill != FILL_MAX) begin
                wr.value_we = 1'b1;
                wr.pos_we   = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos_cnt   = r_pos_cnt;
        n_pair_done = r_pair_done;
        n_launch    = 1'b0;
        n_comp      = r_comp;
        n_key_value = r_key_value;
        n_cur_pos   = r_cur_pos;
        n_out_valid = 1'b0;
        n_status    = r_status;
        n_early     = r_early;
        n_cur_out   = r_cur_out;

        if (accept) begin
            n_fill      = fill_eff;
            n_pair_done = pair_eff;
            n_pos_cnt   = pc_eff;
            if (pc_eff[POSITION_BITS]) begin
                // Position counter saturated: no lookup and nothing stored.
                n_out_valid = 1'b1;
                n_status    = ST_FULL;
                n_early     = '0;
                n_cur_out   = OUT_POS_W'({POSITION_BITS{1'b1}});
            end else begin
                n_pos_cnt = pc_eff + 1'b1;
                n_cur_pos = pc_eff[POSITION_BITS-1:0];
                if (pair_eff) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_IGNORED;
                    n_early     = '0;
                    n_cur_out   = OUT_POS_W'(pc_eff[POSITION_BITS-1:0]);
                end else begin
                    n_comp      = comp;
                    n_key_value = i_value;
                    n_launch    = 1'b1;
                    n_state     = S_SEARCH;
                end
            end
        end

        if (done) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_early     = '0;
            n_cur_out   = OUT_POS_W'(r_cur_pos);
            if (tok[TABLE_ENTRIES].comp_hit) begin
                n_status    = ST_PAIR;
                n_early     = OUT_POS_W'(hit_pos[TABLE_ENTRIES]);
                n_pair_done = 1'b1;
            end else if (tok[TABLE_ENTRIES].dup_hit) begin
                n_status = ST_STORED;
            end else if (r_fill == FILL_MAX) begin
                n_status = ST_FULL;
            end else begin
                n_status = ST_STORED;
                n_fill   = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_fill      <= '0;
            r_pos_cnt   <= '0;
            r_pair_done <= 1'b0;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pos_cnt   <= n_pos_cnt;
            r_pair_done <= n_pair_done;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_target <= i_target_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_comp      <= n_comp;
        r_key_value <= n_key_value;
        r_cur_pos   <= n_cur_pos;
        r_status    <= n_status;
        r_early     <= n_early;
        r_cur_out   <= n_cur_out;
    end

    // The row of table cells; the search token moves one cell per clock.
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        psc_cell #(
            .IDX           (k),
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .POSITION_BITS (POSITION_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_comp      (r_comp),
            .i_key_value (r_key_value),
            .i_fill      (r_fill),
            .i_tok       (tok[k]),
            .i_hit_pos   (hit_pos[k]),
            .i_dup_idx   (dup_idx[k]),
            .i_wr        (wr),
            .i_wr_idx    (wr_idx),
            .i_wr_value  (r_key_value),
            .i_wr_pos    (r_cur_pos),
            .o_tok       (tok[k+1]),
            .o_hit_pos   (hit_pos[k+1]),
            .o_dup_idx   (dup_idx[k+1])
        );
    end

    assign o_result_valid     = r_out_valid;
    assign o_status           = r_status;
    assign o_earlier_position = r_early;
    assign o_current_position = r_cur_out;

    `PSC_ASSERT_SAME(a_launch_in_search, r_launch, r_state == S_SEARCH, "launch outside a search")
    `PSC_ASSERT_SAME(a_token_in_search, tok[TABLE_ENTRIES].valid, r_state == S_SEARCH, "stray token")
    `PSC_ASSERT_NEXT(a_search_result, done, o_result_valid && (r_state == S_IDLE), "search lost")
    `PSC_ASSERT_ALWAYS(a_fill_bound, r_fill <= FILL_MAX, "fill count beyond table size")
    `PSC_ASSERT_SAME(a_pair_flag, o_result_valid && (o_status == ST_PAIR), r_pair_done, "pair flag")

endmodule

[hdl/psc_cell.sv]
module psc_cell #(
    parameter int IDX           = 0,
    parameter int TABLE_ENTRIES = psc_pkg::DEF_TABLE_ENTRIES,
    parameter int POSITION_BITS = psc_pkg::DEF_POSITION_BITS,
    localparam int FW = $clog2(TABLE_ENTRIES + 1),
    localparam int IW = $clog2(TABLE_ENTRIES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [psc_pkg::VALUE_W:0]    i_comp,
    input  logic [psc_pkg::VALUE_W-1:0]  i_key_value,
    input  logic [FW-1:0]                i_fill,
    input  psc_pkg::t_psc_token          i_tok,
    input  logic [POSITION_BITS-1:0]     i_hit_pos,
    input  logic [IW-1:0]                i_dup_idx,
    input  psc_pkg::t_psc_wr             i_wr,
    input  logic [IW-1:0]                i_wr_idx,
    input  logic [psc_pkg::VALUE_W-1:0]  i_wr_value,
    input  logic [POSITION_BITS-1:0]     i_wr_pos,
    output psc_pkg::t_psc_token          o_tok,
    output logic [POSITION_BITS-1:0]     o_hit_pos,
    output logic [IW-1:0]                o_dup_idx
);
    import psc_pkg::*;

    localparam logic [FW-1:0] IDX_F = FW'(IDX);
    localparam logic [IW-1:0] IDX_I = IW'(IDX);

    logic [VALUE_W-1:0]       r_value;
    logic [POSITION_BITS-1:0] r_pos;
    t_psc_token               r_tok;
    t_psc_token               n_tok;
    logic [POSITION_BITS-1:0] r_hit_pos;
    logic [POSITION_BITS-1:0] n_hit_pos;
    logic [IW-1:0]            r_dup_idx;
    logic [IW-1:0]            n_dup_idx;
    logic                     occupied;
    logic                     comp_match;
    logic                     dup_match;

    // An entry counts only once it lies below the fill count.
    assign occupied   = (IDX_F < i_fill);
    assign comp_match = occupied && ({r_value[VALUE_W-1], r_value} == i_comp);
    assign dup_match  = occupied && (r_value == i_key_value);

    always_comb begin
        n_tok     = i_tok;
        n_hit_pos = i_hit_pos;
        n_dup_idx = i_dup_idx;
        if (i_tok.valid && !i_tok.comp_hit && comp_match) begin
            n_tok.comp_hit = 1'b1;
            n_hit_pos      = r_pos;
        end
        if (i_tok.valid && !i_tok.dup_hit && dup_match) begin
            n_tok.dup_hit = 1'b1;
            n_dup_idx     = IDX_I;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_pos <= n_hit_pos;
        r_dup_idx <= n_dup_idx;
        if (i_wr.value_we && (i_wr_idx == IDX_I)) begin
            r_value <= i_wr_value;
        end
        if (i_wr.pos_we && (i_wr_idx == IDX_I)) begin
            r_pos <= i_wr_pos;
        end
    end

    assign o_tok     = r_tok;
    assign o_hit_pos = r_hit_pos;
    assign o_dup_idx = r_dup_idx;

endmodule
